/* src/gsd_pkg.sv */
package gsd_pkg;

    // Key and text widths.
    localparam int KEY_W          = 31;
    localparam int BYTE_W         = 8;
    localparam int MAX_KEY_DIGITS = 10;
    localparam int DIGIT_W        = 4;
    localparam int LEN_W          = $clog2(MAX_KEY_DIGITS + 1);
    localparam int IDX_W          = (MAX_KEY_DIGITS > 1) ? $clog2(MAX_KEY_DIGITS) : 1;
    localparam int CNT_W          = $clog2(KEY_W + 1);

    // Letter arithmetic.
    localparam int OFF_W = 5;
    localparam logic [OFF_W:0] ALPHABET_SIZE = 6'd26;
    localparam logic [DIGIT_W-1:0] BCD_ADJUST_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJUST       = 4'd3;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decimal digits of the key, least significant digit at index 0.
    typedef logic [MAX_KEY_DIGITS-1:0][DIGIT_W-1:0] key_digits_t;

    // Key state handed from the key unit to the front part.
    typedef struct packed {
        key_digits_t          digits;
        logic [LEN_W-1:0]     len;
        logic                 busy;
        logic                 load;
    } key_info_t;

    // One classified item on its way to the back part.
    typedef struct packed {
        logic [BYTE_W-1:0]   text_byte;
        logic                is_letter;
        logic                is_upper;
        logic [OFF_W-1:0]    offset;
        logic [DIGIT_W-1:0]  shift;
    } queue_item_t;

endpackage

/* src/gsd_key_unit.sv */
module gsd_key_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gsd_pkg::KEY_W-1:0]   decimal_key,
    output gsd_pkg::key_info_t          key_info
);

    logic                              busy_reg,  busy_next;
    logic [gsd_pkg::CNT_W-1:0]         cnt_reg,   cnt_next;
    logic [gsd_pkg::KEY_W-1:0]         bin_reg,   bin_next;
    gsd_pkg::key_digits_t              bcd_reg,   bcd_next;
    logic                              ovf_reg,   ovf_next;
    gsd_pkg::key_digits_t              digits_reg, digits_next;
    logic [gsd_pkg::LEN_W-1:0]         len_reg,   len_next;

    gsd_pkg::key_digits_t              bcd_adj;
    gsd_pkg::key_digits_t              bcd_shift;
    logic                              ovf_shift;
    logic [gsd_pkg::LEN_W-1:0]         len_calc;
    logic                              load;

    assign cfg_ready = !busy_reg;
    assign load      = cfg_valid && !busy_reg;

    // One step of the shift-and-add-three binary to decimal conversion.
    always_comb
    begin
        for (int i = 0; i < gsd_pkg::MAX_KEY_DIGITS; i++)
        begin
            if (bcd_reg[i] >= gsd_pkg::BCD_ADJUST_LIMIT)
            begin
                bcd_adj[i] = bcd_reg[i] + gsd_pkg::BCD_ADJUST;
            end
            else
            begin
                bcd_adj[i] = bcd_reg[i];
            end
        end
        bcd_shift = gsd_pkg::key_digits_t'({bcd_adj, bin_reg[gsd_pkg::KEY_W-1]});
        // A bit leaving the top digit means the key has more digits than are kept.
        ovf_shift = ovf_reg || bcd_adj[gsd_pkg::MAX_KEY_DIGITS-1][gsd_pkg::DIGIT_W-1];
    end

    // Number of digits in use: up to the highest non-zero digit, at least one.
    always_comb
    begin
        len_calc = gsd_pkg::LEN_W'(1);
        for (int i = 0; i < gsd_pkg::MAX_KEY_DIGITS; i++)
        begin
            if (bcd_shift[i] != '0)
            begin
                len_calc = gsd_pkg::LEN_W'(i + 1);
            end
        end
        if (ovf_shift)
        begin
            len_calc = gsd_pkg::LEN_W'(gsd_pkg::MAX_KEY_DIGITS);
        end
    end

    // Conversion control.
    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        ovf_next    = ovf_reg;
        digits_next = digits_reg;
        len_next    = len_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = gsd_pkg::CNT_W'(gsd_pkg::KEY_W);
            bin_next  = decimal_key;
            bcd_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - gsd_pkg::CNT_W'(1);
            bin_next = {bin_reg[gsd_pkg::KEY_W-2:0], 1'b0};
            bcd_next = bcd_shift;
            ovf_next = ovf_shift;
            if (cnt_reg == gsd_pkg::CNT_W'(1))
            begin
                busy_next   = 1'b0;
                digits_next = bcd_shift;
                len_next    = len_calc;
            end
        end
    end

    // Registers; after reset the key is one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            digits_reg <= gsd_pkg::key_digits_t'(1);
            len_reg    <= gsd_pkg::LEN_W'(1);
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
        end
    end

    // Conversion working registers.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign key_info.digits = digits_reg;
    assign key_info.len    = len_reg;
    assign key_info.busy   = busy_reg;
    assign key_info.load   = load;

endmodule

/* src/gsd_front.sv */
module gsd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gsd_pkg::BYTE_W-1:0]    text_byte,
    input  logic                          message_start,
    input  gsd_pkg::key_info_t            key_info,
    input  logic                          queue_full,
    output logic                          push,
    output gsd_pkg::queue_item_t          push_item
);

    logic [gsd_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic [gsd_pkg::LEN_W-1:0] pos_use;
    logic [gsd_pkg::LEN_W-1:0] digit_idx;
    logic                      is_upper;
    logic                      is_lower;
    logic [gsd_pkg::BYTE_W-1:0] base;

    assign in_stall = key_info.busy || queue_full;
    assign push     = in_valid && !in_stall;

    // Classify the byte.
    assign is_upper = (text_byte >= gsd_pkg::CHAR_UPPER_A) && (text_byte <= gsd_pkg::CHAR_UPPER_Z);
    assign is_lower = (text_byte >= gsd_pkg::CHAR_LOWER_A) && (text_byte <= gsd_pkg::CHAR_LOWER_Z);
    assign base     = is_upper ? gsd_pkg::CHAR_UPPER_A : gsd_pkg::CHAR_LOWER_A;

    // Pick the current key digit, most significant digit first.
    always_comb
    begin
        pos_use = message_start ? '0 : pos_reg;
        if (pos_use >= key_info.len)
        begin
            pos_use = '0;
        end
        digit_idx = key_info.len - gsd_pkg::LEN_W'(1) - pos_use;
    end

    assign push_item.text_byte = text_byte;
    assign push_item.is_letter = is_upper || is_lower;
    assign push_item.is_upper  = is_upper;
    assign push_item.offset    = gsd_pkg::OFF_W'(text_byte - base);
    assign push_item.shift     = key_info.digits[digit_idx[gsd_pkg::IDX_W-1:0]];

    // Digit position advances on letters only and wraps at the key length.
    always_comb
    begin
        pos_next = pos_reg;
        if (key_info.load)
        begin
            pos_next = '0;
        end
        else if (push)
        begin
            pos_next = pos_use;
            if (is_upper || is_lower)
            begin
                if (pos_use + gsd_pkg::LEN_W'(1) >= key_info.len)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_use + gsd_pkg::LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* src/gsd_queue.sv */
module gsd_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  gsd_pkg::queue_item_t    push_item,
    input  logic                    pop,
    output gsd_pkg::queue_item_t    pop_item,
    output logic                    full,
    output logic                    empty
);

    gsd_pkg::queue_item_t           entries [gsd_pkg::QUEUE_DEPTH];
    logic [gsd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [gsd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [gsd_pkg::QCNT_W-1:0]     count_reg,  count_next;

    assign full     = (count_reg == gsd_pkg::QCNT_W'(gsd_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entries[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == gsd_pkg::QPTR_W'(gsd_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + gsd_pkg::QPTR_W'(1);
            end
        end
        if (pop)
        begin
            if (rd_ptr_reg == gsd_pkg::QPTR_W'(gsd_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + gsd_pkg::QPTR_W'(1);
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + gsd_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - gsd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/gsd_back.sv */
module gsd_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  gsd_pkg::queue_item_t          pop_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gsd_pkg::BYTE_W-1:0]    plain_byte
);

    logic                         out_valid_reg, out_valid_next;
    logic [gsd_pkg::BYTE_W-1:0]   plain_byte_reg;
    logic [gsd_pkg::OFF_W:0]      diff;
    logic [gsd_pkg::OFF_W-1:0]    off_dec;
    logic [gsd_pkg::BYTE_W-1:0]   base;
    logic [gsd_pkg::BYTE_W-1:0]   result;

    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    // Shift the letter back by the key digit, wrapping within 26 letters.
    always_comb
    begin
        diff = (gsd_pkg::OFF_W + 1)'(pop_item.offset) - (gsd_pkg::OFF_W + 1)'(pop_item.shift);
        if (diff[gsd_pkg::OFF_W])
        begin
            diff = diff + gsd_pkg::ALPHABET_SIZE;
        end
        off_dec = diff[gsd_pkg::OFF_W-1:0];
        base    = pop_item.is_upper ? gsd_pkg::CHAR_UPPER_A : gsd_pkg::CHAR_LOWER_A;
        if (pop_item.is_letter)
        begin
            result = base + gsd_pkg::BYTE_W'(off_dec);
        end
        else
        begin
            result = pop_item.text_byte;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            plain_byte_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign plain_byte = plain_byte_reg;

endmodule

/* src/gronsfeld_stream_decrypt_unit.sv */
// Gronsfeld stream decryptor: each item carries one ciphertext byte and yields one plaintext
// byte, in order, letters shifted back by the current key digit and all other bytes passed
// through. Items stream at one per cycle while the input is not stalled, and the result of
// an accepted item reaches the output register by way of the queue; the path runs through a
// classifying front part, a two-item queue and a shifting back part, and the input stalls once
// the queue holds two items behind a stalled result.
// Writing the key starts a shift-and-add-three conversion to decimal digits that works through
// the 31 key bits in turn; no item is accepted until it finishes. A key write and
// message_start both return the digit position to the most significant digit.
module gronsfeld_stream_decrypt_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gsd_pkg::BYTE_W-1:0]    text_byte,
    input  logic                          message_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gsd_pkg::BYTE_W-1:0]    plain_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gsd_pkg::KEY_W-1:0]     decimal_key
);

    gsd_pkg::key_info_t     key_info;
    gsd_pkg::queue_item_t   push_item;
    gsd_pkg::queue_item_t   pop_item;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    logic                   queue_empty;

    // Key register and digit extraction.
    gsd_key_unit u_key
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .decimal_key (decimal_key),
        .key_info    (key_info)
    );

    // Front part: accept, classify and pick the digit.
    gsd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .message_start (message_start),
        .key_info      (key_info),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Queue between the two parts.
    gsd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back part: shift and present the result.
    gsd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .plain_byte  (plain_byte)
    );

endmodule
